FILE: design/bezier_patch_evaluator_top_defines.svh
// Assertion macros shared by the checker.
`ifndef BEZIER_PATCH_EVALUATOR_TOP_DEFINES_SVH
`define BEZIER_PATCH_EVALUATOR_TOP_DEFINES_SVH

// Clocked implication, held off during reset.
`define BPE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bpe_pkg.sv
package bpe_pkg;
	localparam int GRID_SIZE_DEF = 4;
	localparam int COORD_W = 24;
	localparam int PARAM_W = 17;
	localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;
endpackage

FILE: design/bpe_ram.sv
module bpe_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/bpe_cell.sv
// One de Casteljau cell: holds one point, lerps it toward its right neighbor.
module bpe_cell (
	input  logic                     clk,
	input  logic                     load,
	input  logic                     step,
	input  bpe_pkg::point_t          load_pt,
	input  bpe_pkg::point_t          right_pt,
	input  logic [bpe_pkg::PARAM_W-1:0] t,
	output bpe_pkg::point_t          pt
);
	import bpe_pkg::*;

	point_t pt_q;
	point_t lerp_pt;

	function automatic coord_t lerp(coord_t a, coord_t b, logic [PARAM_W-1:0] tt);
		logic signed [42:0] p;
		logic signed [25:0] d;
		d = 26'(b) - 26'(a);
		p = 43'(a) * 43'sd65536 + 43'(d) * $signed({1'b0, tt}) + 43'sd32768;
		return coord_t'(p >>> 16);
	endfunction

	always_comb begin
		lerp_pt.x = lerp(pt_q.x, right_pt.x, t);
		lerp_pt.y = lerp(pt_q.y, right_pt.y, t);
		lerp_pt.z = lerp(pt_q.z, right_pt.z, t);
	end

	always_ff @(posedge clk) begin
		if (load)
			pt_q <= load_pt;
		else if (step)
			pt_q <= lerp_pt;
	end

	assign pt = pt_q;
endmodule

FILE: design/bezier_patch_evaluator_top.sv
// Bicubic Bezier patch evaluator (de Casteljau).
// s_axis: one transaction per command. tuser = cmd (0 load, 1 evaluate).
//   Load writes tdata point into grid[row][col]; out-of-range index ignored.
//   Evaluate uses param_u/param_v (values above one clamp to one).
// m_axis: one transaction per evaluate, tdata = surface x,y,z.
// Datapath: a row of GRID_SIZE cells. Each row is read from the RAM one
// point per cycle into the cells, then GRID_SIZE-1 reduction steps run, all
// cells lerping in parallel toward their right neighbor; cell 0 then holds
// the row result, which goes to a column buffer. The column is then loaded
// into the cells and reduced along v.
// Evaluate handles one item at a time, set by the shared cell row. The next
// transaction is accepted the cycle after the result is taken. A load
// leaves the controller in IDLE.
// The result sits in an output register; while the receiver stalls, no new
// transaction is accepted. Reset clears control only; grid contents are
// undefined until loaded.
module bezier_patch_evaluator_top #(
	parameter int GRID_SIZE = bpe_pkg::GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: grid_row[1:0], grid_col[3:2], point_x, point_y, point_z,
	//        param_u, param_v, zero fill to 112 bits
	input  logic [111:0] s_axis_tdata,
	input  logic        s_axis_tuser, // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: surface_x, surface_y, surface_z
	output logic [71:0] m_axis_tdata
);
	import bpe_pkg::*;

	localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int IW = $clog2(GRID_SIZE);
	localparam int CW = $clog2(GRID_SIZE + 1) + 1;

	typedef enum logic [2:0] {IDLE, FILL, REDUCE, CFILL, CREDUCE, DONE} state_t;
	state_t state_q;

	logic [1:0] in_row, in_col;
	point_t in_pt;
	logic [PARAM_W-1:0] in_u, in_v, u_q, v_q;
	assign in_row = s_axis_tdata[1:0];
	assign in_col = s_axis_tdata[3:2];
	assign in_pt = point_t'(s_axis_tdata[75:4]);
	assign in_u = s_axis_tdata[92:76];
	assign in_v = s_axis_tdata[109:93];

	logic accept;
	assign s_axis_tready = (state_q == IDLE) && !m_axis_tvalid;
	assign accept = s_axis_tvalid && s_axis_tready;

	logic we;
	assign we = accept && s_axis_tuser == CMD_LOAD &&
		32'(in_row) < GRID_SIZE && 32'(in_col) < GRID_SIZE;

	logic [IW-1:0] row_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] raddr;
	point_t rdata;
	assign raddr = AW'(32'(row_q) * GRID_SIZE + 32'(cnt_q));

	bpe_ram #(.WIDTH(3 * COORD_W), .DEPTH(GRID_SIZE * GRID_SIZE)) u_ram (
		.clk(clk), .we(we),
		.waddr(AW'(32'(in_row) * GRID_SIZE + 32'(in_col))),
		.wdata(in_pt), .raddr(raddr), .rdata(rdata)
	);

	point_t col_q [GRID_SIZE];
	point_t cell_pt [GRID_SIZE];
	logic [GRID_SIZE-1:0] cell_load;
	logic cell_step;
	point_t load_pt;
	logic [PARAM_W-1:0] t_cur;

	// RAM data arrives the cycle after the address; cnt counts addresses.
	assign load_pt = (state_q == CFILL) ? col_q[cnt_q[IW-1:0]] : rdata;
	assign t_cur = (state_q == CREDUCE) ? v_q : u_q;
	assign cell_step = (state_q == REDUCE) || (state_q == CREDUCE);

	always_comb begin
		cell_load = '0;
		if (state_q == FILL && cnt_q != 0)
			cell_load[cnt_q[IW-1:0] - IW'(1)] = 1'b1;
		if (state_q == CFILL && 32'(cnt_q) < GRID_SIZE)
			cell_load[cnt_q[IW-1:0]] = 1'b1;
	end

	for (genvar i = 0; i < GRID_SIZE; i++) begin : g_cell
		bpe_cell u_cell (
			.clk(clk), .load(cell_load[i]), .step(cell_step),
			.load_pt(load_pt),
			.right_pt(cell_pt[(i + 1 < GRID_SIZE) ? i + 1 : i]),
			.t(t_cur), .pt(cell_pt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			m_axis_tvalid <= 1'b0;
			cnt_q <= '0;
			row_q <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept && s_axis_tuser == CMD_EVAL) begin
						u_q <= (in_u > ONE_Q16) ? ONE_Q16 : in_u;
						v_q <= (in_v > ONE_Q16) ? ONE_Q16 : in_v;
						row_q <= '0;
						cnt_q <= '0;
						state_q <= FILL;
					end
				end
				FILL: begin
					if (32'(cnt_q) == GRID_SIZE) begin
						cnt_q <= '0;
						state_q <= REDUCE;
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				REDUCE: begin
					if (32'(cnt_q) == GRID_SIZE - 2) begin
						cnt_q <= '0;
						if (32'(row_q) == GRID_SIZE - 1)
							state_q <= CFILL;
						else begin
							row_q <= row_q + IW'(1);
							state_q <= FILL;
						end
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				CFILL: begin
					if (32'(cnt_q) == GRID_SIZE - 1) begin
						cnt_q <= '0;
						state_q <= CREDUCE;
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				CREDUCE: begin
					if (32'(cnt_q) == GRID_SIZE - 2) begin
						cnt_q <= '0;
						state_q <= DONE;
					end else
						cnt_q <= cnt_q + CW'(1);
				end
				DONE: begin
					m_axis_tdata <= cell_pt[0];
					m_axis_tvalid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Row result capture: cell 0 holds it the cycle after the last step.
	logic row_done_q;
	logic [IW-1:0] row_done_idx_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_done_q <= 1'b0;
		else
			row_done_q <= state_q == REDUCE && 32'(cnt_q) == GRID_SIZE - 2;
	end
	always_ff @(posedge clk) begin
		row_done_idx_q <= row_q;
		if (row_done_q)
			col_q[row_done_idx_q] <= cell_pt[0];
	end
endmodule

FILE: design/bpe_checker.sv
module bpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);
	`include "bezier_patch_evaluator_top_defines.svh"

	`BPE_ASSERT_IMP(a_no_accept_while_out, m_axis_tvalid, !s_axis_tready, "accept during pending result")
	`BPE_ASSERT_NEXT(a_eval_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "ready after evaluate")
	`BPE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`BPE_ASSERT_NEXT(a_load_quick, s_axis_tvalid && s_axis_tready && !s_axis_tuser, s_axis_tready || m_axis_tvalid, "load stalled input")
endmodule

bind bezier_patch_evaluator_top bpe_checker u_bpe_checker (.*);

FILE: dv/tb_bezier_patch_evaluator_top.sv
`timescale 1ns / 100ps

module tb_bezier_patch_evaluator_top;
	import bpe_pkg::*;

	localparam int G = GRID_SIZE_DEF;
	localparam int N_RANDOM = 1000;
	localparam longint CYCLE_LIMIT = 1500000;

	// one pending input transaction: tuser and packed tdata
	typedef struct {
		logic         cmd;
		logic [111:0] data;
	} patch_cmd_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [71:0]  m_axis_tdata;

	bezier_patch_evaluator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state: grid points in offset-binary form, as in the lerp math.
	logic [23:0]  grid_ob [G*G][3];
	patch_cmd_t   cmd_queue [$];
	logic [71:0]  surface_queue [$];
	int           error_count = 0;
	longint       cycle_count = 0;
	bit           idle_enable = 1'b1;
	bit           hold_request = 1'b0;
	bit           stim_done = 1'b0;
	int           hold_cycles = 0;
	int           send_idle_left = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [23:0] got,
		input logic [23:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
		error_count++;
	endtask

	// round-to-nearest lerp on offset-binary coordinates
	function automatic logic [23:0] lerp_ob(input logic [23:0] a, input logic [23:0] b,
		input logic [16:0] t);
		logic [63:0] p;
		p = 64'(a) * 64'(17'h10000 - t) + 64'(b) * 64'(t) + 64'd32768;
		return p[39:16];
	endfunction

	function automatic logic [71:0] evaluate_surface(input logic [16:0] u_in,
		input logic [16:0] v_in);
		logic [23:0] row_pts [G][3];
		logic [23:0] col_pts [G][3];
		logic [16:0] u, v;
		logic [71:0] res;
		u = (u_in > ONE_Q16) ? ONE_Q16 : u_in;
		v = (v_in > ONE_Q16) ? ONE_Q16 : v_in;
		for (int r = 0; r < G; r++) begin
			for (int c = 0; c < G; c++)
				for (int k = 0; k < 3; k++) row_pts[c][k] = grid_ob[r*G+c][k];
			for (int n = G; n > 1; n--)
				for (int i = 0; i < n-1; i++)
					for (int k = 0; k < 3; k++)
						row_pts[i][k] = lerp_ob(row_pts[i][k], row_pts[i+1][k], u);
			for (int k = 0; k < 3; k++) col_pts[r][k] = row_pts[0][k];
		end
		for (int n = G; n > 1; n--)
			for (int i = 0; i < n-1; i++)
				for (int k = 0; k < 3; k++)
					col_pts[i][k] = lerp_ob(col_pts[i][k], col_pts[i+1][k], v);
		for (int k = 0; k < 3; k++) res[k*24 +: 24] = col_pts[0][k] ^ 24'h800000;
		return res;
	endfunction

	function automatic logic [111:0] pack_fields(input logic [1:0] row,
		input logic [1:0] col, input logic [23:0] x, input logic [23:0] y,
		input logic [23:0] z, input logic [16:0] u, input logic [16:0] v);
		return {4'b0, v, u, z, y, x, col, row};
	endfunction

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] rand_param();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return ONE_Q16;
			2: return 17'($urandom_range(65537, 131071)); // above one, clamps
			3: return 17'd32768;
			default: return 17'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_load(input logic [1:0] row, input logic [1:0] col,
		input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
		patch_cmd_t item;
		item.cmd = CMD_LOAD;
		item.data = pack_fields(row, col, x, y, z, 17'($urandom), 17'($urandom));
		cmd_queue.insert(cmd_queue.size(), item);
	endtask

	task automatic push_eval(input logic [16:0] u, input logic [16:0] v);
		patch_cmd_t item;
		item.cmd = CMD_EVAL;
		item.data = pack_fields(2'($urandom), 2'($urandom), 24'($urandom),
			24'($urandom), 24'($urandom), u, v);
		cmd_queue.insert(cmd_queue.size(), item);
	endtask

	task automatic load_full_grid(input int style);
		for (int r = 0; r < G; r++)
			for (int c = 0; c < G; c++)
				case (style)
					0: push_load(2'(r), 2'(c), 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
					1: push_load(2'(r), 2'(c), 24'h800000, 24'h7FFFFF, 24'h000000);
					default: push_load(2'(r), 2'(c), rand_coord(), rand_coord(),
						rand_coord());
				endcase
	endtask

	// Driver: pops the next transaction when the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			send_idle_left = 0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_axis_tvalid && s_axis_tready) begin
					// accepted transaction updates the predictor
					if (s_axis_tuser == CMD_LOAD) begin
						for (int k = 0; k < 3; k++)
							grid_ob[{s_axis_tdata[1:0], s_axis_tdata[3:2]}][k] =
								s_axis_tdata[4 + 24*k +: 24] ^ 24'h800000;
					end else begin
						surface_queue.insert(surface_queue.size(),
							evaluate_surface(s_axis_tdata[92:76], s_axis_tdata[109:93]));
					end
				end
				if (send_idle_left > 0) begin
					send_idle_left--;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0 && idle_enable &&
					$urandom_range(0, 7) == 0) begin
					// idle burst: tvalid low while send_idle_left counts down
					send_idle_left = $urandom_range(1, 18) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (cmd_queue.size() > 0) begin
					patch_cmd_t item;
					item = cmd_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= item.cmd;
					s_axis_tdata <= item.data;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver backpressure: random bursts, plus a long hold on request.
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else if (hold_request && hold_cycles < 400) begin
			hold_cycles++;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: compares each output transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (surface_queue.size() == 0) begin
				report_mismatch("unexpected output", m_axis_tdata[23:0], 24'hx);
			end else begin
				logic [71:0] want;
				want = surface_queue.pop_front();
				if (m_axis_tdata[23:0] !== want[23:0])
					report_mismatch("surface_x", m_axis_tdata[23:0], want[23:0]);
				if (m_axis_tdata[47:24] !== want[47:24])
					report_mismatch("surface_y", m_axis_tdata[47:24], want[47:24]);
				if (m_axis_tdata[71:48] !== want[71:48])
					report_mismatch("surface_z", m_axis_tdata[71:48], want[71:48]);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bezier_patch_evaluator_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		// Directed: extreme grids, parameter extremes and clamping, ignored fields.
		load_full_grid(0);
		push_eval(17'd0, 17'd0);
		push_eval(ONE_Q16, ONE_Q16);
		push_eval(17'h1FFFF, 17'd32768);
		load_full_grid(1);
		push_eval(17'd32768, 17'h1FFFF);
		push_eval(17'd1, 17'd65535);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (cmd_queue.size() == 0);
		// Random: full grid reloads, single-point loads, evaluations and one eval burst.
		load_full_grid(2);
		for (int n = 0; n < N_RANDOM; ) begin
			if (n >= N_RANDOM/3 && !hold_request) begin
				// long receiver hold while evaluations keep coming
				hold_request = 1'b1;
				for (int i = 0; i < 8; i++) push_eval(rand_param(), rand_param());
				n += 8;
			end
			if (n > N_RANDOM*4/5) idle_enable = 1'b0;
			case ($urandom_range(0, 9))
				0: begin load_full_grid(2); n += G*G; end
				1, 2, 3: begin
					push_load(2'($urandom), 2'($urandom), rand_coord(), rand_coord(),
						rand_coord());
					n++;
				end
				default: begin push_eval(rand_param(), rand_param()); n++; end
			endcase
			wait (cmd_queue.size() < 20);
		end
		wait (cmd_queue.size() == 0 && !s_axis_tvalid);
		wait (surface_queue.size() == 0);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("bezier_patch_evaluator_top verification clean");
		else
			$display("bezier_patch_evaluator_top verification failed");
		$finish;
	end
endmodule
